>>> rtl/core/csc_pkg.sv
// package for the compaction score calculator
// types, constants and helpers shared by the front, queue, divider and back modules
// no dependencies
package csc_pkg;

   // port widths
   localparam int REQ_DATA_W = 176;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // product and divider widths
   localparam int PROD_W   = 50;
   localparam int QD_NUM_W = 82;
   localparam int QD_DEN_W = 50;
   localparam int QD_Q_W   = 63;
   localparam int QD_LAT   = QD_Q_W + 1;

   // queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // fixed constants
   localparam logic [31:0] EPS_Q32       = 32'd42949;
   localparam logic [19:0] DEF_READ_IOPS  = 20'd100;
   localparam logic [19:0] DEF_WRITE_IOPS = 20'd300;
   localparam logic [31:0] DEF_BANDWIDTH  = 32'd31457280;
   localparam logic [63:0] SCORE_MIN      = 64'h8000_0000_0000_0000;

   // score kinds
   localparam logic KIND_BLOB = 1'b0;
   localparam logic KIND_COST = 1'b1;

   // register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_POLICY_MODE     = 3'd0,
      CSR_BLOB_LIMIT      = 3'd1,
      CSR_BLOCK_BYTES     = 3'd2,
      CSR_MAX_BLOB_BYTES  = 3'd3,
      CSR_READ_IOPS       = 3'd4,
      CSR_READ_BANDWIDTH  = 3'd5,
      CSR_WRITE_IOPS      = 3'd6,
      CSR_WRITE_BANDWIDTH = 3'd7
   } csc_csr_type;

   // item classes decided in the front
   typedef enum logic [1:0] {
      CLS_THRESH,
      CLS_EMPTY,
      CLS_OVER,
      CLS_COST
   } csc_class_type;

   // configuration with defaults already resolved
   typedef struct packed {
      logic        mode;
      logic [15:0] blob_limit;
      logic [17:0] block_bytes;
      logic [31:0] max_blob_bytes;
      logic [19:0] r_iops;
      logic [31:0] r_bw;
      logic [19:0] w_iops;
      logic [31:0] w_bw;
   } csc_cfg_type;

   // classified word passed from front to back
   typedef struct packed {
      csc_class_type     cls;
      logic [15:0]       blobs;
      logic [31:0]       hits;
      logic [31:0]       reqs;
      logic [PROD_W-1:0] rb;
      logic [PROD_W-1:0] ub;
      logic [PROD_W-1:0] mden;
      logic              blocks_zero;
   } csc_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } csc_fifo_status_type;

   // per-word control carried beside the dividers
   typedef struct packed {
      csc_class_type cls;
      logic [15:0]   blobs;
      logic          rb_nz;
      logic          data_nz;
   } csc_side_type;

   typedef struct packed {
      csc_side_type      side;
      logic [63:0]       dval;
      logic [QD_Q_W-1:0] wr;
      logic [QD_Q_W-1:0] d5;
   } csc_mid_type;

   // saturating add of two non-negative q31.32 values
   function automatic logic [QD_Q_W-1:0] sadd(input logic [QD_Q_W-1:0] a,
                                              input logic [QD_Q_W-1:0] b);
      logic [QD_Q_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[QD_Q_W] ? {QD_Q_W{1'b1}} : s[QD_Q_W-1:0];
   endfunction

endpackage

>>> rtl/core/csc_qdiv.sv
// pipelined restoring divider, one quotient bit per stage, saturating
// gives min(floor(num / den), 2^63 - 1); a zero divisor saturates
// depends on csc_pkg
module csc_qdiv import csc_pkg::*; (
   input  logic                clock,
   input  logic                en,
   input  logic [QD_NUM_W-1:0] num,
   input  logic [QD_DEN_W-1:0] den,
   output logic [QD_Q_W-1:0]   quot
);

   logic [QD_DEN_W-1:0] rem_ff  [QD_LAT];
   logic [QD_DEN_W-1:0] den_ff  [QD_LAT];
   logic [QD_Q_W-1:0]   low_ff  [QD_LAT];
   logic [QD_Q_W-1:0]   quot_ff [QD_LAT];
   logic                ovf_ff  [QD_LAT];

   logic [QD_DEN_W:0]   trial   [1:QD_LAT-1];
   logic                ge      [1:QD_LAT-1];

   // trial subtract of each stage
   always_comb begin
      for (int i = 1; i < QD_LAT; i++) begin
         trial[i] = {rem_ff[i-1], low_ff[i-1][QD_Q_W-1]};
         ge[i]    = trial[i] >= {1'b0, den_ff[i-1]};
      end
   end

   // stage 0 takes the high part as the first remainder
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= QD_DEN_W'(num[QD_NUM_W-1:QD_Q_W]);
         ovf_ff[0]  <= QD_DEN_W'(num[QD_NUM_W-1:QD_Q_W]) >= den;
         den_ff[0]  <= den;
         low_ff[0]  <= num[QD_Q_W-1:0];
         quot_ff[0] <= '0;
         for (int i = 1; i < QD_LAT; i++) begin
            den_ff[i]  <= den_ff[i-1];
            ovf_ff[i]  <= ovf_ff[i-1];
            low_ff[i]  <= {low_ff[i-1][QD_Q_W-2:0], 1'b0};
            quot_ff[i] <= {quot_ff[i-1][QD_Q_W-2:0], ge[i]};
            if (ge[i]) begin
               rem_ff[i] <= QD_DEN_W'(trial[i] - {1'b0, den_ff[i-1]});
            end else begin
               rem_ff[i] <= trial[i][QD_DEN_W-1:0];
            end
         end
      end
   end

   assign quot = ovf_ff[QD_LAT-1] ? {QD_Q_W{1'b1}} : quot_ff[QD_LAT-1];

endmodule

>>> rtl/core/csc_front.sv
// front part: accepts range statistics, classifies them, forms the byte products
// depends on csc_pkg
module csc_front import csc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  csc_cfg_type           cfg,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // blob_total, block_total, used_blocks, read_requests, read_blob_hits,
   // read_block_total
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  full,
   output logic                  push,
   output csc_item_type          item,
   output logic                  busy
);

   logic [15:0]  blobs;
   logic [31:0]  blocks, used, reqs, hits, rblocks;
   logic         advance;
   logic         f_valid_ff;
   csc_item_type f_item_ff;
   csc_item_type f_item_in;

   assign blobs   = req_tdata[15:0];
   assign blocks  = req_tdata[47:16];
   assign used    = req_tdata[79:48];
   assign reqs    = req_tdata[111:80];
   assign hits    = req_tdata[143:112];
   assign rblocks = req_tdata[175:144];

   // classify and form products
   always_comb begin
      f_item_in.blobs       = blobs;
      f_item_in.hits        = hits;
      f_item_in.reqs        = reqs;
      f_item_in.rb          = PROD_W'(rblocks) * PROD_W'(cfg.block_bytes);
      f_item_in.ub          = PROD_W'(used) * PROD_W'(cfg.block_bytes);
      f_item_in.blocks_zero = (blocks == 32'd0);
      if (blocks == 32'd0) begin
         f_item_in.mden = PROD_W'(1);
      end else begin
         f_item_in.mden = PROD_W'(blocks) * PROD_W'(cfg.block_bytes);
      end
      priority if (!cfg.mode) begin
         f_item_in.cls = CLS_THRESH;
      end else if (blobs == 16'd0) begin
         f_item_in.cls = CLS_EMPTY;
      end else if (blobs > cfg.blob_limit) begin
         f_item_in.cls = CLS_OVER;
      end else begin
         f_item_in.cls = CLS_COST;
      end
   end

   // one word of staging ahead of the queue
   assign advance    = !f_valid_ff || !full;
   assign req_tready = advance;
   assign push       = f_valid_ff && !full;
   assign item       = f_item_ff;
   assign busy       = f_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (advance) begin
         f_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_tvalid) begin
         f_item_ff <= f_item_in;
      end
   end

endmodule

>>> rtl/core/csc_fifo.sv
// short queue of classified words between front and back
// depends on csc_pkg
module csc_fifo import csc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  csc_item_type        push_item,
   input  logic                pop,
   output csc_item_type        pop_item,
   output csc_fifo_status_type status
);

   csc_item_type          mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;
   logic                  do_push, do_pop;

   assign status.full  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_item     = mem[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> rtl/core/csc_back.sv
// back part: cost arithmetic over two divider rows, final saturation, output register
// depends on csc_pkg and csc_qdiv
module csc_back import csc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  csc_cfg_type           cfg,
   input  logic                  empty,
   input  csc_item_type          item,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // score
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // score_kind
   output logic                  rsp_tuser
);

   logic en;

   // stage a: word taken from the queue
   logic         a_valid_ff;
   csc_item_type a_item_ff;
   // stage b: capped data size
   logic         b_valid_ff;
   csc_item_type b_item_ff;
   logic [31:0]  b_data_ff, b_data_in;
   // stage c: data times blob count
   logic         c_valid_ff;
   csc_item_type c_item_ff;
   logic [31:0]  c_data_ff;
   logic [47:0]  c_datab_ff;

   // first divider row
   logic [QD_NUM_W-1:0] n1, n2, n3, n4, n5, n6, n7, n8;
   logic [QD_Q_W-1:0]   q1, q2, q3, q4, q5, q6, q7, q8;
   csc_side_type        side_c;
   logic [QD_LAT-1:0]   s1_valid_ff;
   csc_side_type        s1_ff [QD_LAT];

   // second divider row
   csc_mid_type       mid_in;
   logic [QD_Q_W-1:0] rcost, ccost;
   logic [QD_LAT-1:0] s2_valid_ff;
   csc_mid_type       s2_ff [QD_LAT];

   // stage e and f
   logic              e_valid_ff;
   csc_mid_type       e_mid_ff;
   logic [QD_Q_W-1:0] e_rd_ff;
   logic              f_valid_ff;
   csc_side_type      f_side_ff;
   logic [63:0]       f_dval_ff;
   logic [QD_Q_W-1:0] f_comp_ff, f_comp_in;

   // output
   logic        rsp_valid_ff;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [64:0] diff;

   // whole back pipe moves unless the output word is held
   assign en  = !rsp_valid_ff || rsp_tready;
   assign pop = en && !empty;

   // valid bits of every stage
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         s1_valid_ff  <= '0;
         s2_valid_ff  <= '0;
         e_valid_ff   <= 1'b0;
         f_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff   <= !empty;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         s1_valid_ff  <= {s1_valid_ff[QD_LAT-2:0], c_valid_ff};
         s2_valid_ff  <= {s2_valid_ff[QD_LAT-2:0], s1_valid_ff[QD_LAT-1]};
         e_valid_ff   <= s2_valid_ff[QD_LAT-1];
         f_valid_ff   <= e_valid_ff;
         rsp_valid_ff <= f_valid_ff;
      end
   end

   // cap the live data at the largest blob
   always_comb begin
      if (a_item_ff.ub > PROD_W'(cfg.max_blob_bytes)) begin
         b_data_in = cfg.max_blob_bytes;
      end else begin
         b_data_in = a_item_ff.ub[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         a_item_ff <= item;
      end
      if (en) begin
         b_item_ff  <= a_item_ff;
         b_data_ff  <= b_data_in;
         c_item_ff  <= b_item_ff;
         c_data_ff  <= b_data_ff;
         c_datab_ff <= 48'(b_data_ff) * 48'(b_item_ff.blobs);
      end
   end

   // dividends of the first row
   always_comb begin
      n1 = QD_NUM_W'({c_item_ff.hits, 32'd0});
      n2 = {c_item_ff.rb, 32'd0};
      n3 = QD_NUM_W'({c_item_ff.reqs, 32'd0});
      if (c_item_ff.blocks_zero) begin
         n4 = QD_NUM_W'({c_item_ff.blobs, 32'd0});
      end else begin
         n4 = QD_NUM_W'({c_datab_ff, 32'd0});
      end
      n5 = QD_NUM_W'({c_data_ff, 32'd0});
      n6 = QD_NUM_W'({1'b1, 32'd0});
      n7 = QD_NUM_W'({c_data_ff, 32'd0});
      n8 = QD_NUM_W'(q4);
      side_c.cls     = c_item_ff.cls;
      side_c.blobs   = c_item_ff.blobs;
      side_c.rb_nz   = (c_item_ff.rb != '0);
      side_c.data_nz = (c_data_ff != 32'd0);
   end

   csc_qdiv u_div_hits (.clock, .en, .num(n1), .den(QD_DEN_W'(cfg.r_iops)), .quot(q1));
   csc_qdiv u_div_rbw  (.clock, .en, .num(n2), .den(QD_DEN_W'(cfg.r_bw)),   .quot(q2));
   csc_qdiv u_div_reqs (.clock, .en, .num(n3), .den(QD_DEN_W'(cfg.r_iops)), .quot(q3));
   csc_qdiv u_div_mb   (.clock, .en, .num(n4), .den(c_item_ff.mden),        .quot(q4));
   csc_qdiv u_div_drd  (.clock, .en, .num(n5), .den(QD_DEN_W'(cfg.r_bw)),   .quot(q5));
   csc_qdiv u_div_wop  (.clock, .en, .num(n6), .den(QD_DEN_W'(cfg.w_iops)), .quot(q6));
   csc_qdiv u_div_dwr  (.clock, .en, .num(n7), .den(QD_DEN_W'(cfg.w_bw)),   .quot(q7));
   // blob count read cost rides behind the first row
   csc_qdiv u_div_mbr  (.clock, .en, .num(n8), .den(QD_DEN_W'(cfg.r_iops)), .quot(q8));

   // control beside the first row
   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff[0] <= side_c;
         for (int i = 1; i < QD_LAT; i++) begin
            s1_ff[i] <= s1_ff[i-1];
         end
      end
   end

   // read cost difference and write cost after the first row
   always_comb begin
      if (s1_ff[QD_LAT-1].rb_nz) begin
         rcost = sadd(q1, q2);
         ccost = sadd(q3, q2);
      end else begin
         rcost = '0;
         ccost = '0;
      end
      mid_in.side = s1_ff[QD_LAT-1];
      mid_in.dval = {1'b0, rcost} - {1'b0, ccost};
      mid_in.wr   = sadd(q6, q7);
      mid_in.d5   = q5;
   end

   // control beside the second row
   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff[0] <= mid_in;
         for (int i = 1; i < QD_LAT; i++) begin
            s2_ff[i] <= s2_ff[i-1];
         end
      end
   end

   // compaction cost in two steps
   always_comb begin
      if (e_mid_ff.side.data_nz) begin
         f_comp_in = sadd(e_rd_ff, e_mid_ff.wr);
      end else begin
         f_comp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_mid_ff  <= s2_ff[QD_LAT-1];
         e_rd_ff   <= sadd(q8, s2_ff[QD_LAT-1].d5);
         f_side_ff <= e_mid_ff.side;
         f_dval_ff <= e_mid_ff.dval;
         f_comp_ff <= f_comp_in;
      end
   end

   // final score with saturation at the low bound
   always_comb begin
      diff = {f_dval_ff[63], f_dval_ff} - {2'b00, f_comp_ff};
      unique case (f_side_ff.cls)
         CLS_THRESH: begin
            rsp_data_in = {32'(f_side_ff.blobs) - 32'(cfg.blob_limit), EPS_Q32};
            rsp_kind_in = KIND_BLOB;
         end
         CLS_EMPTY: begin
            rsp_data_in = '0;
            rsp_kind_in = KIND_BLOB;
         end
         CLS_OVER: begin
            rsp_data_in = {16'd0, f_side_ff.blobs, 32'd0};
            rsp_kind_in = KIND_BLOB;
         end
         CLS_COST: begin
            rsp_data_in = (diff[64] != diff[63]) ? SCORE_MIN : diff[63:0];
            rsp_kind_in = KIND_COST;
         end
         default: begin
            rsp_data_in = '0;
            rsp_kind_in = KIND_BLOB;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en && f_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= rsp_kind_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule

>>> rtl/core/compaction_score_calc_top.sv
// Compaction score calculator, top level: configuration registers, front, queue, back.
// Depends on csc_pkg, csc_front, csc_fifo, csc_back and csc_qdiv.
//
// Usage:
//   req_* carries one word of range statistics; rsp_* returns one word per request:
//   a signed q31.32 score in rsp_tdata and the score kind in rsp_tuser.
//   csr_* writes one of the eight policy registers per cycle; write it only while
//   no word is in flight. Zero iops or bandwidth selects the built-in default.
//   Throughput: one word per cycle when the receiver is ready; each division is a
//   64-stage pipeline producing one quotient bit per stage, and the blob-count
//   read cost divider follows the first divider row, which sets the latency.
//   Reset clears the queue and every valid bit and loads the register
//   defaults. When the receiver stalls, the back pipe holds; the queue of four
//   words and the front staging word keep taking requests until they fill.
module compaction_score_calc_top import csc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // blob_total, block_total, used_blocks, read_requests, read_blob_hits,
   // read_block_total
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // score
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // score_kind
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic        mode_ff;
   logic [15:0] blob_limit_ff;
   logic [17:0] block_bytes_ff;
   logic [31:0] max_blob_bytes_ff;
   logic [19:0] read_iops_ff;
   logic [31:0] read_bw_ff;
   logic [19:0] write_iops_ff;
   logic [31:0] write_bw_ff;

   csc_cfg_type         cfg;
   csc_item_type        front_item, fifo_item;
   csc_fifo_status_type fifo_status;
   logic                fifo_push, fifo_pop, front_busy;

   // policy registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= 1'b0;
         blob_limit_ff     <= 16'd1;
         block_bytes_ff    <= 18'd4096;
         max_blob_bytes_ff <= 32'd4194304;
         read_iops_ff      <= '0;
         read_bw_ff        <= '0;
         write_iops_ff     <= '0;
         write_bw_ff       <= '0;
      end else if (csr_we) begin
         unique case (csc_csr_type'(csr_addr))
            CSR_POLICY_MODE:     mode_ff           <= csr_wdata[0];
            CSR_BLOB_LIMIT:      blob_limit_ff     <= csr_wdata[15:0];
            CSR_BLOCK_BYTES:     block_bytes_ff    <= csr_wdata[17:0];
            CSR_MAX_BLOB_BYTES:  max_blob_bytes_ff <= csr_wdata;
            CSR_READ_IOPS:       read_iops_ff      <= csr_wdata[19:0];
            CSR_READ_BANDWIDTH:  read_bw_ff        <= csr_wdata;
            CSR_WRITE_IOPS:      write_iops_ff     <= csr_wdata[19:0];
            CSR_WRITE_BANDWIDTH: write_bw_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // defaults for zero rates
   always_comb begin
      cfg.mode           = mode_ff;
      cfg.blob_limit     = blob_limit_ff;
      cfg.block_bytes    = block_bytes_ff;
      cfg.max_blob_bytes = max_blob_bytes_ff;
      cfg.r_iops         = (read_iops_ff != '0) ? read_iops_ff : DEF_READ_IOPS;
      cfg.r_bw           = (read_bw_ff != '0) ? read_bw_ff : DEF_BANDWIDTH;
      cfg.w_iops         = (write_iops_ff != '0) ? write_iops_ff : DEF_WRITE_IOPS;
      cfg.w_bw           = (write_bw_ff != '0) ? write_bw_ff : DEF_BANDWIDTH;
   end

   csc_front u_front (
      .clock,
      .reset,
      .cfg,
      .req_tvalid,
      .req_tready,
      .req_tdata,
      .full  (fifo_status.full),
      .push  (fifo_push),
      .item  (front_item),
      .busy  (front_busy)
   );

   csc_fifo u_fifo (
      .clock,
      .reset,
      .push      (fifo_push),
      .push_item (front_item),
      .pop       (fifo_pop),
      .pop_item  (fifo_item),
      .status    (fifo_status)
   );

   csc_back u_back (
      .clock,
      .reset,
      .cfg,
      .empty (fifo_status.empty),
      .item  (fifo_item),
      .pop   (fifo_pop),
      .rsp_tvalid,
      .rsp_tready,
      .rsp_tdata,
      .rsp_tuser
   );

   // reset empties queue and output
   assert property (@(posedge clock) reset |=> !rsp_tvalid && fifo_status.empty)
      else $error("queue or output not cleared by reset");

   // back takes a word only when the output can move
   assert property (@(posedge clock) disable iff (reset)
      fifo_pop |-> (!rsp_tvalid || rsp_tready))
      else $error("queue popped while output held");

   // front refuses requests when staging and queue are both full
   assert property (@(posedge clock) disable iff (reset)
      (fifo_status.full && front_busy) |-> !req_tready)
      else $error("request accepted with no room");

endmodule
